FILE: hdl/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// Standalone package; used by lir_serial_mul and linear_interp_resampler.
package lir_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SAMPLE_W  = 16;
	localparam int STEP_W    = 18;

	// Difference of two samples, and the multiplier's partial-product register.
	localparam int DELTA_W   = SAMPLE_W + 1;
	localparam int PROD_W    = DELTA_W + 1;

	// Phase stays below one unit plus one maximal step.
	localparam int PHASE_W   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 2;
	localparam int MCNT_W    = $clog2(FRAC_BITS + 1);

	localparam int RUN_MAX   = 64;
	localparam int RUN_W     = $clog2(RUN_MAX);

	localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
	localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

FILE: hdl/lir_serial_mul.sv
// Bit-serial signed-by-unsigned multiplier that returns floor(delta * frac / 2^FRAC_BITS).
// Depends on lir_pkg.
module lir_serial_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [lir_pkg::DELTA_W-1:0]    delta,
	input  logic        [lir_pkg::FRAC_BITS-1:0]  phase_frac,
	output lir_pkg::mul_stat_t                    stat,
	output logic signed [lir_pkg::PROD_W-1:0]     scaled
);

	logic signed [lir_pkg::PROD_W-1:0]    hi_q;
	logic signed [lir_pkg::DELTA_W-1:0]   delta_q;
	logic        [lir_pkg::FRAC_BITS-1:0] frac_q;
	logic        [lir_pkg::MCNT_W-1:0]    cnt_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic signed [lir_pkg::PROD_W-1:0]    addend;
	logic signed [lir_pkg::PROD_W-1:0]    sum;

	// One multiplier bit per cycle, LSB first; the shifted-out bits are
	// the dropped fraction, so the final high part is already the floor.
	assign addend = frac_q[0] ? lir_pkg::PROD_W'(delta_q) : '0;
	assign sum    = hi_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= lir_pkg::MCNT_W'(lir_pkg::FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == lir_pkg::MCNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q    <= '0;
			delta_q <= delta;
			frac_q  <= phase_frac;
		end else if (busy_q) begin
			hi_q   <= sum >>> 1;
			frac_q <= frac_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign scaled    = hi_q;

endmodule

FILE: hdl/linear_interp_resampler.sv
// Linear interpolation sample rate converter with a 4.16 phase accumulator; uses
// lir_pkg and lir_serial_mul. Each result is formed by the bit-serial multiplier; an
// input is taken, its phase is checked, and then each of its results is multiplied in
// turn. One transaction at a time is in progress.
// Asynchronous active-low reset clears samples, phase and priming state, loads a step
// of one unit and empties the output register.
module linear_interp_resampler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic        [lir_pkg::STEP_W-1:0]    cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [lir_pkg::SAMPLE_W-1:0]  source_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lir_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                                 last_of_run
);

	localparam int SUM_W = lir_pkg::PROD_W + 1;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 <<< (lir_pkg::SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 <<< (lir_pkg::SAMPLE_W - 1));

	// ST_CHECK decides whether a run starts, ST_MUL waits on the serial
	// multiplier, ST_EMIT waits for room in the output register.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_EMIT
	} state_t;

	// Priming: nothing loaded, previous sample loaded, running.
	typedef enum logic [1:0] {
		PRIME_EMPTY,
		PRIME_HALF,
		PRIME_RUN
	} prime_t;

	state_t                                state_q;
	prime_t                                prime_q;
	logic signed [lir_pkg::SAMPLE_W-1:0]   prev_q;
	logic signed [lir_pkg::SAMPLE_W-1:0]   next_q;
	logic        [lir_pkg::PHASE_W-1:0]    phase_q;
	logic        [lir_pkg::STEP_W-1:0]     step_q;
	logic        [lir_pkg::RUN_W-1:0]      run_cnt_q;
	logic                                  out_valid_q;
	logic signed [lir_pkg::SAMPLE_W-1:0]   out_sample_q;
	logic                                  last_q;

	logic                                  phase_below;
	logic        [lir_pkg::PHASE_W-1:0]    phase_sum;
	logic                                  emit_ok;
	logic                                  emit_last;
	logic                                  mul_start;
	logic signed [lir_pkg::DELTA_W-1:0]    delta;
	logic        [lir_pkg::FRAC_BITS-1:0]  mul_frac;
	lir_pkg::mul_stat_t                    mul_stat;
	logic signed [lir_pkg::PROD_W-1:0]     scaled;
	logic signed [SUM_W-1:0]               y_sum;
	logic signed [lir_pkg::SAMPLE_W-1:0]   y_sat;

	assign in_ready = (state_q == ST_IDLE);

	// The phase is below one unit when its integer part is zero.
	assign phase_below = (phase_q[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] == '0);
	assign phase_sum   = phase_q + lir_pkg::PHASE_W'(step_q);

	// A result can move into the output register when it is empty or is
	// being drained in this same cycle.
	assign emit_ok = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// The run ends when the advanced phase reaches one unit, or at the cap.
	assign emit_last = (phase_sum[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] != '0) ||
	                   (run_cnt_q == lir_pkg::RUN_W'(lir_pkg::RUN_MAX - 1));

	// The multiplier starts at the head of a run, and again right after each
	// emitted result that is not the last, using the advanced phase.
	assign mul_start = ((state_q == ST_CHECK) && phase_below) || (emit_ok && !emit_last);
	assign mul_frac  = emit_ok ? phase_sum[lir_pkg::FRAC_BITS-1:0]
	                           : phase_q[lir_pkg::FRAC_BITS-1:0];
	assign delta     = lir_pkg::DELTA_W'(next_q) - lir_pkg::DELTA_W'(prev_q);

	lir_serial_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mul_start),
		.delta      (delta),
		.phase_frac (mul_frac),
		.stat       (mul_stat),
		.scaled     (scaled)
	);

	// Interpolated value, then saturation to the sample range.
	assign y_sum = SUM_W'(prev_q) + SUM_W'(scaled);

	always_comb begin
		if (y_sum > SAT_HI) begin
			y_sat = SAT_HI[lir_pkg::SAMPLE_W-1:0];
		end else if (y_sum < SAT_LO) begin
			y_sat = SAT_LO[lir_pkg::SAMPLE_W-1:0];
		end else begin
			y_sat = y_sum[lir_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prime_q      <= PRIME_EMPTY;
			prev_q       <= '0;
			next_q       <= '0;
			phase_q      <= '0;
			step_q       <= lir_pkg::STEP_RESET;
			run_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				step_q <= cfg_wr_data;
			end

			// The output register fills on an emitted result and empties when
			// the receiver takes its transaction with nothing new behind it.
			if (emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (prime_q)
							PRIME_EMPTY: begin
								// The first sample only loads the previous one.
								prev_q  <= source_sample;
								prime_q <= PRIME_HALF;
							end
							PRIME_HALF: begin
								next_q  <= source_sample;
								prime_q <= PRIME_RUN;
								state_q <= ST_CHECK;
							end
							default: begin
								// Running: shift the pair and consume one source unit.
								// The subtraction floors at zero after a capped run.
								prev_q  <= next_q;
								next_q  <= source_sample;
								phase_q <= phase_below ? '0 : phase_q - lir_pkg::PHASE_ONE;
								state_q <= ST_CHECK;
							end
						endcase
					end
				end
				ST_CHECK: begin
					run_cnt_q <= '0;
					state_q   <= phase_below ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						out_sample_q <= y_sat;
						last_q       <= emit_last;
						phase_q      <= phase_sum;
						run_cnt_q    <= run_cnt_q + 1'b1;
						state_q      <= emit_last ? ST_IDLE : ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign last_of_run = last_q;

`ifndef SYNTHESIS
	// No new transaction is taken while a product is being formed.
	a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mul_stat.busy)
		else $error("input accepted while the multiplier is busy");

	// A finished product is only reported while the controller waits for it.
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_MUL))
		else $error("multiplier finished outside the multiply state");

	// Interpolation only runs with a phase below one unit.
	a_phase_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> phase_below)
		else $error("interpolating with a phase of one unit or more");

	// The result that reaches the cap always closes the run.
	a_cap_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_ok && (run_cnt_q == lir_pkg::RUN_W'(lir_pkg::RUN_MAX - 1))) |=> last_q)
		else $error("run cap reached without marking the last result");
`endif

endmodule
